>>> hw/rtl/fcsg_pkg.sv
// Shared types and constants for the four-channel square sound generator.
// No dependencies; the core imports this package.
package fcsg_pkg;

  localparam int COUNT_WIDTH = 18;
  localparam int RATE_WIDTH  = 18;
  localparam int DIV_WIDTH   = 22;
  localparam int FREQ_WIDTH  = 11;

  localparam logic [DIV_WIDTH-1:0]  CLOCK_NUM  = 22'd3072000;
  localparam logic [RATE_WIDTH-1:0] RATE_RESET = 18'd48000;

  // Operation codes of one input transaction.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Register offsets.
  localparam logic [7:0] OFF_FREQ_LO  = 8'h80;
  localparam logic [7:0] OFF_FREQ_HI  = 8'h87;
  localparam logic [7:0] OFF_VOL_LO   = 8'h88;
  localparam logic [7:0] OFF_VOL_HI   = 8'h8B;
  localparam logic [7:0] OFF_SWEEP_D  = 8'h8C;
  localparam logic [7:0] OFF_SWEEP_T  = 8'h8D;
  localparam logic [7:0] OFF_CONTROL  = 8'h90;
  localparam logic [7:0] OFF_MASTER   = 8'h94;

  typedef struct packed {
    logic       opcode;
    logic [7:0] port_offset;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic signed [17:0] left_sample;
    logic signed [17:0] right_sample;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIV_A = 3'b010,
    ST_DIV_B = 3'b100
  } state_t;

endpackage

>>> hw/rtl/four_channel_square_sound_generator_core.sv
// Four-channel square sound generator core with a shared serial divider.
// Depends on fcsg_pkg for item types, offsets and state codes.
//
//   channel | signals                          | carries
//   in      | in_valid, in_ready, in_data      | register write or sample tick
//   out     | out_valid, out_ready, out_data   | stereo sample pair
//   cfg     | cfg_valid, cfg_ready, cfg_data   | output sample rate
//
// A tick without a sweep step and a write that needs no period need no division.
// A frequency write, a sweep time write or a sweep step runs two 22-step
// restoring divisions through one shared divider: the block is busy until both
// are done and takes no new transaction before then.
// Reset (rst, synchronous) clears all channel state; the rate returns to 48000.
// A waiting result stalls further input until it is taken.
module four_channel_square_sound_generator_core
  import fcsg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RATE_WIDTH-1:0] cfg_data
);

  logic [RATE_WIDTH-1:0]  audio_rate;
  logic [FREQ_WIDTH-1:0]  freq [4];
  logic [15:0]            half [4];
  logic [15:0]            pos [4];
  logic [3:0]             neg;
  logic [3:0]             vol_l [4];
  logic [3:0]             vol_r [4];
  logic [3:0]             en;
  logic                   voice_mode, sweep_mode, noise_mode;
  logic [7:0]             voice_byte, master_level, sweep_delta;
  logic [COUNT_WIDTH-1:0] sweep_interval, sweep_counter;

  state_t                 state;
  logic [DIV_WIDTH-1:0]   rem, quo, divisor;
  logic [4:0]             step;
  logic                   tgt_sweep;
  logic [1:0]             tgt_ch;

  // Serial divider step: one quotient bit per cycle.
  logic [DIV_WIDTH:0]     rem_sh;
  logic                   fits;
  logic [DIV_WIDTH-1:0]   rem_next, quo_next;
  assign rem_sh   = {rem, quo[DIV_WIDTH-1]};
  assign fits     = rem_sh >= {1'b0, divisor};
  assign rem_next = fits ? DIV_WIDTH'(rem_sh - {1'b0, divisor}) : rem_sh[DIV_WIDTH-1:0];
  assign quo_next = {quo[DIV_WIDTH-2:0], fits};

  assign in_ready  = (state == ST_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // Decode of a register write.
  logic [7:0]            off, wd;
  logic                  is_freq, is_vol;
  logic [1:0]            wch;
  logic [FREQ_WIDTH-1:0] wfreq;
  assign off     = in_data.port_offset;
  assign wd      = in_data.write_data;
  assign is_freq = (off >= OFF_FREQ_LO) && (off <= OFF_FREQ_HI);
  assign is_vol  = (off >= OFF_VOL_LO) && (off <= OFF_VOL_HI);
  assign wch     = is_freq ? off[2:1] : off[1:0];
  assign wfreq   = off[0] ? {wd[2:0], freq[wch][7:0]} : {freq[wch][10:8], wd};

  // Per-channel step and mix terms for a tick.
  logic [3:0]        adv, wrap;
  logic [16:0]       p1 [4];
  logic signed [9:0] term_l [4];
  logic signed [9:0] term_r [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      p1[i]     = {1'b0, pos[i]} + 17'd1;
      wrap[i]   = p1[i] >= {1'b0, half[i]};
      term_l[i] = neg[i] ? -$signed({2'b0, vol_l[i], 4'b0}) : $signed({2'b0, vol_l[i], 4'b0});
      term_r[i] = neg[i] ? -$signed({2'b0, vol_r[i], 4'b0}) : $signed({2'b0, vol_r[i], 4'b0});
    end
    adv[0] = en[0];
    adv[1] = en[1] && !voice_mode;
    adv[2] = en[2];
    adv[3] = en[3] && !noise_mode;
  end

  // Voice sample on channel 2.
  logic signed [9:0]  voice_s;
  logic signed [14:0] voice_term;
  logic               voice_on;
  assign voice_s    = $signed(10'({2'b0, voice_byte}) - 10'd128);
  assign voice_term = voice_s * $signed({1'b0, master_level[3:0]});
  assign voice_on   = en[1] && voice_mode;

  // Mix both sides.
  logic signed [17:0] sum_l, sum_r;
  always_comb begin
    sum_l = voice_on ? 18'(voice_term) : '0;
    sum_r = sum_l;
    for (int i = 0; i < 4; i++) begin
      if (adv[i]) begin
        sum_l = sum_l + 18'(term_l[i]);
        sum_r = sum_r + 18'(term_r[i]);
      end
    end
  end

  // Sweep counter on channel 3.
  logic                   sweep_on, sweep_fire;
  logic [COUNT_WIDTH-1:0] cnt1;
  logic [FREQ_WIDTH-1:0]  swept;
  assign sweep_on   = en[2] && sweep_mode && (sweep_interval != '0);
  assign cnt1       = sweep_counter + 1'b1;
  assign sweep_fire = sweep_on && (cnt1 >= sweep_interval);
  assign swept      = freq[2] + {{3{sweep_delta[7]}}, sweep_delta};

  // Divisor of the first division for a period: the period span.
  function automatic logic [DIV_WIDTH-1:0] span_of(logic [FREQ_WIDTH-1:0] f);
    logic [11:0] diff;
    diff = 12'd2048 - {1'b0, f};
    return {5'b0, diff, 5'b0};
  endfunction

  // Sequencer, channel state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      audio_rate     <= RATE_RESET;
      neg            <= '0;
      en             <= '0;
      voice_mode     <= 1'b0;
      sweep_mode     <= 1'b0;
      noise_mode     <= 1'b0;
      voice_byte     <= '0;
      master_level   <= '0;
      sweep_delta    <= '0;
      sweep_interval <= '0;
      sweep_counter  <= '0;
      for (int i = 0; i < 4; i++) begin
        freq[i]  <= '0;
        half[i]  <= '0;
        pos[i]   <= '0;
        vol_l[i] <= '0;
        vol_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        audio_rate <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && in_data.opcode == OP_TICK) begin
            out_valid             <= 1'b1;
            out_data.left_sample  <= {sum_l[12:0], 5'b0};
            out_data.right_sample <= {sum_r[12:0], 5'b0};
            for (int i = 0; i < 4; i++) begin
              if (adv[i]) begin
                pos[i] <= wrap[i] ? 16'd0 : p1[i][15:0];
                if (wrap[i]) neg[i] <= ~neg[i];
              end
            end
            if (sweep_on) begin
              sweep_counter <= sweep_fire ? '0 : cnt1;
            end
            if (sweep_fire) begin
              freq[2]   <= swept;
              tgt_sweep <= 1'b0;
              tgt_ch    <= 2'd2;
              divisor   <= span_of(swept);
              quo       <= CLOCK_NUM;
              rem       <= '0;
              step      <= '0;
              state     <= ST_DIV_A;
            end
          end else if (in_fire) begin
            if (is_freq) begin
              freq[wch] <= wfreq;
              tgt_sweep <= 1'b0;
              tgt_ch    <= wch;
              divisor   <= span_of(wfreq);
              quo       <= CLOCK_NUM;
              rem       <= '0;
              step      <= '0;
              state     <= ST_DIV_A;
            end else if (is_vol) begin
              vol_l[wch] <= wd[7:4];
              vol_r[wch] <= wd[3:0];
              if (wch == 2'd1) voice_byte <= wd;
            end else if (off == OFF_SWEEP_D) begin
              sweep_delta <= wd;
            end else if (off == OFF_SWEEP_T) begin
              tgt_sweep <= 1'b1;
              tgt_ch    <= '0;
              divisor   <= {9'(wd) + 9'd1, 13'b0};
              quo       <= CLOCK_NUM;
              rem       <= '0;
              step      <= '0;
              state     <= ST_DIV_A;
            end else if (off == OFF_CONTROL) begin
              en         <= wd[3:0];
              voice_mode <= wd[5];
              sweep_mode <= wd[6];
              noise_mode <= wd[7];
            end else if (off == OFF_MASTER) begin
              master_level <= wd;
            end
          end
        end
        // Clock over span or sweep unit.
        ST_DIV_A: begin
          if (step == 5'(DIV_WIDTH - 1)) begin
            divisor <= quo_next;
            quo     <= {{(DIV_WIDTH-RATE_WIDTH){1'b0}}, audio_rate};
            rem     <= '0;
            step    <= '0;
            state   <= ST_DIV_B;
          end else begin
            rem  <= rem_next;
            quo  <= quo_next;
            step <= step + 5'd1;
          end
        end
        // Rate over the first quotient, then store the count.
        ST_DIV_B: begin
          if (step == 5'(DIV_WIDTH - 1)) begin
            if (tgt_sweep) begin
              sweep_interval <= (quo_next[DIV_WIDTH-1:COUNT_WIDTH] != '0) ?
                                '1 : quo_next[COUNT_WIDTH-1:0];
            end else begin
              half[tgt_ch] <= quo_next[16:1];
            end
            state <= ST_IDLE;
          end else begin
            rem  <= rem_next;
            quo  <= quo_next;
            step <= step + 5'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
